/* hdl/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, widths and codes for the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // table geometry
  localparam int NUM_BLOCKS = 8;
  localparam int SIZE_BITS  = 16;

  // fixed field widths of the item ports
  localparam int REQ_W  = 16;   // request_size / load_size / left_over
  localparam int LIDX_W = 3;    // load_index / granted_index
  localparam int BC_W   = 4;    // block_count register
  localparam int CFG_W  = 4;    // widest configuration register
  localparam int CFGI_W = 1;    // configuration register index

  // derived widths
  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int N_W    = (CNT_W > BC_W) ? CNT_W : BC_W;
  localparam int LX_W   = (LIDX_W > IDX_W) ? LIDX_W : IDX_W;
  localparam int CMP_W  = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  // reset value of block_count
  localparam logic [BC_W-1:0] BC_RESET = BC_W'(8);

  // placement policies
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_mode_t;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_FIT_MODE    = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_W-1:0]     idx_t;

  // write port of the free size table
  typedef struct packed {
    logic  en;
    idx_t  idx;
    size_t data;
  } tbl_wr_t;

endpackage

/* hdl/partition_fit_allocator.sv */
// ----------------------------------------------------------------------------
// partition_fit_allocator
// Places size requests into a table of free partitions by first, best, worst
// or next fit; load items write table entries.
// ----------------------------------------------------------------------------
// A load item writes its table entry when accepted and gives no result. A
// request has an accept step, a scan of one table entry per cycle over the
// n entries in use (n at most 8), and an update step; first and next fit
// stop early on a hit. One request at a time uses the single compare unit
// and the single table read port; no new item is taken before it commits.
// Reset (synchronous, rst_n low): table cleared, pointer zero, first fit,
// block_count 8.
module partition_fit_allocator
  import pfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFGI_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [LIDX_W-1:0]     in_load_index,
  input  logic [REQ_W-1:0]      in_load_size,
  input  logic [REQ_W-1:0]      in_request_size,
  input  logic                  in_batch_end,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_granted,
  output logic [LIDX_W-1:0]     out_granted_index,
  output logic [REQ_W-1:0]      out_left_over,
  output logic                  out_batch_done
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  fit_mode_t        fit_mode_r;
  logic [BC_W-1:0]  block_count_r;
  idx_t             ptr_r;
  idx_t             idx_r;
  idx_t             pick_r;
  logic [CNT_W-1:0] rem_r;
  logic             have_r;
  size_t            best_r;
  logic [REQ_W-1:0] req_r;
  logic             batch_r;

  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [LIDX_W-1:0]    out_index_r;
  logic [REQ_W-1:0]     out_left_r;
  logic                 out_batch_r;

  logic [N_W-1:0]   bc_x;
  logic [CNT_W-1:0] n_used;
  idx_t             start_idx;
  logic             in_fire;
  logic             out_fire;
  logic             commit;
  logic             last_idx;
  logic             take;
  logic             early_hit;
  logic [LX_W-1:0]  load_x;
  logic             load_ok;

  tbl_wr_t          tbl_wr;
  idx_t             rd_idx;
  size_t            rd_data;
  logic             fits;
  logic             better;
  size_t            diff;

  // handshakes
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign commit   = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);

  // entries in use, capped at the table depth
  assign bc_x   = N_W'(block_count_r);
  assign n_used = (bc_x > N_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bc_x);

  // scan start: kept pointer for next fit when it is inside the used range
  assign start_idx = ((fit_mode_r == FIT_NEXT) && (CNT_W'(ptr_r) < n_used)) ?
                     ptr_r : '0;

  // load index range check, one bit wider so the table depth is representable
  assign load_x  = LX_W'(in_load_index);
  assign load_ok = ((LX_W+1)'(load_x) < (LX_W+1)'(NUM_BLOCKS));

  // table read address: scan position, or the chosen entry at update
  assign rd_idx = (state_r == ST_UPDATE) ? pick_r : idx_r;

  pfa_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  pfa_cmp u_cmp (
    .mode   (fit_mode_r),
    .entry  (rd_data),
    .need   (req_r),
    .best   (best_r),
    .fits   (fits),
    .better (better),
    .diff   (diff)
  );

  // scan step decisions
  assign take      = fits && (!have_r || better);
  assign early_hit = fits && ((fit_mode_r == FIT_FIRST) || (fit_mode_r == FIT_NEXT));
  assign last_idx  = (CNT_W'(idx_r) == (n_used - CNT_W'(1)));

  // table write: load item or committed placement
  always_comb begin
    tbl_wr.en   = 1'b0;
    tbl_wr.idx  = pick_r;
    tbl_wr.data = diff;
    if (in_fire && (in_op == OP_LOAD)) begin
      tbl_wr.en   = load_ok;
      tbl_wr.idx  = IDX_W'(load_x);
      tbl_wr.data = SIZE_BITS'(in_load_size);
    end else if (commit && have_r) begin
      tbl_wr.en = 1'b1;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_PLACE)) begin
          state_nxt = (n_used == '0) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((rem_r == CNT_W'(1)) || early_hit) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fit_mode_r    <= FIT_FIRST;
      block_count_r <= BC_RESET;
      ptr_r         <= '0;
      have_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_MODE:    fit_mode_r    <= fit_mode_t'(cfg_data[1:0]);
          CFG_BLOCK_COUNT: block_count_r <= cfg_data[BC_W-1:0];
          default: ;
        endcase
      end
      if (in_fire && (in_op == OP_PLACE)) begin
        have_r <= 1'b0;
      end else if ((state_r == ST_SCAN) && take) begin
        have_r <= 1'b1;
      end
      if (commit && have_r && (fit_mode_r == FIT_NEXT)) begin
        ptr_r <= pick_r;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && (in_op == OP_PLACE)) begin
      req_r   <= in_request_size;
      batch_r <= in_batch_end;
      rem_r   <= n_used;
      idx_r   <= start_idx;
    end else if (state_r == ST_SCAN) begin
      rem_r <= rem_r - CNT_W'(1);
      idx_r <= last_idx ? '0 : idx_r + IDX_W'(1);
      if (take) begin
        pick_r <= idx_r;
        best_r <= rd_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_granted_r <= have_r;
      out_index_r   <= have_r ? LIDX_W'(pick_r) : '0;
      out_left_r    <= have_r ? REQ_W'(diff) : '0;
      out_batch_r   <= batch_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_granted_index = out_index_r;
  assign out_left_over     = out_left_r;
  assign out_batch_done    = out_batch_r;

endmodule

/* hdl/pfa_table.sv */
// ----------------------------------------------------------------------------
// pfa_table
// Free size table: one write port, one read port, cleared to zero on reset.
// ----------------------------------------------------------------------------
module pfa_table
  import pfa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  tbl_wr_t wr,
  input  idx_t    rd_idx,
  output size_t   rd_data
);

  size_t free_r [NUM_BLOCKS];

  // entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        free_r[i] <= '0;
      end
    end else if (wr.en) begin
      free_r[wr.idx] <= wr.data;
    end
  end

  // single read port
  assign rd_data = free_r[rd_idx];

endmodule

/* hdl/pfa_cmp.sv */
// ----------------------------------------------------------------------------
// pfa_cmp
// Shared compare and subtract unit used by every scan step and the update.
// ----------------------------------------------------------------------------
module pfa_cmp
  import pfa_pkg::*;
(
  input  fit_mode_t        mode,
  input  size_t            entry,
  input  logic [REQ_W-1:0] need,
  input  size_t            best,
  output logic             fits,
  output logic             better,
  output size_t            diff
);

  logic [CMP_W-1:0] entry_x;
  logic [CMP_W-1:0] need_x;
  logic [CMP_W-1:0] diff_x;

  assign entry_x = CMP_W'(entry);
  assign need_x  = CMP_W'(need);

  // request fits when the entry holds at least the full-width request
  assign fits = (entry_x >= need_x);

  // policy compare against the current candidate
  always_comb begin
    case (mode)
      FIT_BEST:  better = (entry < best);
      FIT_WORST: better = (entry > best);
      default:   better = 1'b0;
    endcase
  end

  // remaining free size, cut to the entry width
  assign diff_x = entry_x - need_x;
  assign diff   = SIZE_BITS'(diff_x);

endmodule
